FILE: rtl/ebpf_pkg.sv
package ebpf_pkg;

	localparam int unsigned XLEN = 64;
	localparam int unsigned NUM_GPR = 10;
	localparam logic [3:0] FP_INDEX = 4'd10;
	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [3:0] SHIFT_MASK = 4'd15;

	localparam logic [2:0] CLS_JMP = 3'd5;
	localparam logic [2:0] CLS_ALU64 = 3'd7;
	localparam logic [7:0] OP_LDDW = 8'h18;

	localparam logic [3:0] ALU_ADD = 4'h0;
	localparam logic [3:0] ALU_SUB = 4'h1;
	localparam logic [3:0] ALU_MUL = 4'h2;
	localparam logic [3:0] ALU_DIV = 4'h3;
	localparam logic [3:0] ALU_OR = 4'h4;
	localparam logic [3:0] ALU_AND = 4'h5;
	localparam logic [3:0] ALU_LSH = 4'h6;
	localparam logic [3:0] ALU_RSH = 4'h7;
	localparam logic [3:0] ALU_NEG = 4'h8;
	localparam logic [3:0] ALU_MOD = 4'h9;
	localparam logic [3:0] ALU_XOR = 4'ha;
	localparam logic [3:0] ALU_MOV = 4'hb;
	localparam logic [3:0] ALU_ARSH = 4'hc;

	localparam logic [3:0] JMP_JA = 4'h0;
	localparam logic [3:0] JMP_JEQ = 4'h1;
	localparam logic [3:0] JMP_JGT = 4'h2;
	localparam logic [3:0] JMP_JGE = 4'h3;
	localparam logic [3:0] JMP_JSET = 4'h4;
	localparam logic [3:0] JMP_JNE = 4'h5;
	localparam logic [3:0] JMP_JSGT = 4'h6;
	localparam logic [3:0] JMP_JSGE = 4'h7;
	localparam logic [3:0] JMP_EXIT = 4'h9;
	localparam logic [3:0] JMP_JLT = 4'ha;
	localparam logic [3:0] JMP_JLE = 4'hb;
	localparam logic [3:0] JMP_JSLT = 4'hc;
	localparam logic [3:0] JMP_JSLE = 4'hd;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_start;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic mul_done;
		logic div_done;
	} dp_status_t;

endpackage

FILE: rtl/ebpf_if.sv
interface ebpf_in_if;
	logic valid;
	logic ready;
	logic [7:0] op;
	logic [3:0] dst_index;
	logic [3:0] src_index;
	logic signed [15:0] offset;
	logic signed [31:0] immediate;

	modport source(output valid, op, dst_index, src_index, offset, immediate, input ready);
	modport sink(input valid, op, dst_index, src_index, offset, immediate, output ready);
endinterface

interface ebpf_out_if;
	logic valid;
	logic ready;
	logic signed [16:0] jump_delta;
	logic exit_flag;
	logic [63:0] return_value;
	logic unsupported;

	modport source(output valid, jump_delta, exit_flag, return_value, unsupported, input ready);
	modport sink(input valid, jump_delta, exit_flag, return_value, unsupported, output ready);
endinterface

FILE: rtl/ebpf_alu64_branch_execute.sv
// Executes one decoded eBPF instruction per transfer on the input channel against
// the ten-entry register file; r10 reads as the frame base written on the cfg port.
// Each input transfer yields exactly one output transfer carrying the jump delta,
// the exit flag, r0 after the instruction and the unsupported flag.
// The block works on one instruction at a time. Simple operations and jumps are
// computed in the execute state and registered once the output register is free;
// MUL builds the 64-bit product from three 32-bit partial products on one
// multiplier; DIV and MOD with a non-zero divisor run on the restoring divider,
// which resolves one quotient bit per cycle. The next instruction is taken only
// after the result is registered.
// The result sits in an output register, so the next instruction is accepted while
// a result still waits; if the receiver stalls, the following result is held in
// the datapath until the output register frees, and no further input is taken.
// Reset clears the register file, the frame base and all control state; the block
// is ready for input as soon as reset is released.
module ebpf_alu64_branch_execute import ebpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [XLEN-1:0] cfg_wdata,
	ebpf_in_if.sink in_ch,
	ebpf_out_if.source out_ch
);

	ctrl_cmd_t cmd;
	dp_status_t status;

	ebpf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.status(status),
		.cmd(cmd)
	);

	ebpf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_op(in_ch.op),
		.in_dst_index(in_ch.dst_index),
		.in_src_index(in_ch.src_index),
		.in_offset(in_ch.offset),
		.in_immediate(in_ch.immediate),
		.cmd(cmd),
		.status(status),
		.jump_delta(out_ch.jump_delta),
		.exit_flag(out_ch.exit_flag),
		.return_value(out_ch.return_value),
		.unsupported(out_ch.unsupported)
	);

endmodule

FILE: rtl/ebpf_div.sv
module ebpf_div import ebpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [XLEN-1:0] dividend,
	input logic [XLEN-1:0] divisor,
	output logic done,
	output logic [XLEN-1:0] quotient,
	output logic [XLEN-1:0] remainder
);

	logic [XLEN:0] rem_q;
	logic [XLEN-1:0] quot_q;
	logic [XLEN-1:0] dvs_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [XLEN:0] rem_sh;
	logic [XLEN:0] rem_sub;

	assign rem_sh = {rem_q[XLEN-1:0], quot_q[XLEN-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'(XLEN - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quot_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!rem_sub[XLEN]) begin
				rem_q <= rem_sub;
				quot_q <= {quot_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quot_q <= {quot_q[XLEN-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 7'(XLEN - 1));
	assign quotient = quot_q;
	assign remainder = rem_q[XLEN-1:0];

endmodule

FILE: rtl/ebpf_ctrl.sv
module ebpf_ctrl import ebpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic out_ready,
	output logic out_valid,
	input dp_status_t status,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_mul) begin
					state_d = ST_MUL;
				end else if (status.is_div) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/ebpf_dp.sv
module ebpf_dp import ebpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [XLEN-1:0] cfg_wdata,
	input logic [7:0] in_op,
	input logic [3:0] in_dst_index,
	input logic [3:0] in_src_index,
	input logic signed [15:0] in_offset,
	input logic signed [31:0] in_immediate,
	input ctrl_cmd_t cmd,
	output dp_status_t status,
	output logic signed [16:0] jump_delta,
	output logic exit_flag,
	output logic [XLEN-1:0] return_value,
	output logic unsupported
);

	logic [XLEN-1:0] mem [0:NUM_GPR-1];
	logic [NUM_GPR-1:0] valid_q;
	logic [XLEN-1:0] frame_base_q;
	logic [XLEN-1:0] r0_q;
	logic [XLEN-1:0] rd_d_q, rd_s_q;
	logic vld_d_s1, vld_s_s1;
	logic [7:0] op_s1;
	logic [3:0] dst_s1, src_s1;
	logic signed [15:0] off_s1;
	logic signed [31:0] imm_s1;
	logic [1:0] mul_cnt_q;
	logic [XLEN-1:0] mul_acc_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	logic [2:0] cls;
	logic [3:0] oper;
	logic use_reg;
	logic [XLEN-1:0] imm64, d, s, sreg;
	logic [5:0] sh;
	logic is_alu, is_jmp, is_ld;
	logic alu_ok, jmp_ok, wr;
	logic [XLEN-1:0] res, alu_res;
	logic take, is_exit;
	logic slt_sd, slt_ds;
	logic div_done;
	logic [XLEN-1:0] quo, rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
			valid_q <= '0;
			r0_q <= '0;
		end else begin
			if (cfg_we) begin
				frame_base_q <= cfg_wdata;
			end
			if (cmd.commit && wr) begin
				valid_q[dst_s1] <= 1'b1;
				if (dst_s1 == 4'd0) begin
					r0_q <= res;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr) begin
			mem[dst_s1] <= res;
		end
		if (cmd.load) begin
			op_s1 <= in_op;
			dst_s1 <= in_dst_index;
			src_s1 <= in_src_index;
			off_s1 <= in_offset;
			imm_s1 <= in_immediate;
			vld_d_s1 <= (in_dst_index < FP_INDEX) && valid_q[in_dst_index];
			vld_s_s1 <= (in_src_index < FP_INDEX) && valid_q[in_src_index];
			if (in_dst_index < FP_INDEX) begin
				rd_d_q <= mem[in_dst_index];
			end
			if (in_src_index < FP_INDEX) begin
				rd_s_q <= mem[in_src_index];
			end
		end
	end

	assign cls = op_s1[2:0];
	assign oper = op_s1[7:4];
	assign use_reg = op_s1[3];
	assign imm64 = {{32{imm_s1[31]}}, imm_s1};

	always_comb begin
		if (dst_s1 < FP_INDEX) begin
			d = vld_d_s1 ? rd_d_q : '0;
		end else if (dst_s1 == FP_INDEX) begin
			d = frame_base_q;
		end else begin
			d = '0;
		end
		if (src_s1 < FP_INDEX) begin
			sreg = vld_s_s1 ? rd_s_q : '0;
		end else if (src_s1 == FP_INDEX) begin
			sreg = frame_base_q;
		end else begin
			sreg = '0;
		end
	end

	assign s = use_reg ? sreg : imm64;
	assign sh = s[5:0];
	assign is_alu = (cls == CLS_ALU64);
	assign is_jmp = (cls == CLS_JMP);
	assign is_ld = (op_s1 == OP_LDDW);
	assign alu_ok = is_alu && (oper <= ALU_ARSH);
	assign wr = (alu_ok || is_ld) && (dst_s1 < FP_INDEX);
	assign slt_sd = (s ^ SIGN_BIT) < (d ^ SIGN_BIT);
	assign slt_ds = (d ^ SIGN_BIT) < (s ^ SIGN_BIT);

	always_comb begin
		alu_res = d;
		case (oper)
			ALU_ADD: alu_res = d + s;
			ALU_SUB: alu_res = d - s;
			ALU_MUL: alu_res = mul_acc_q;
			ALU_DIV: alu_res = (s == '0) ? '0 : quo;
			ALU_OR: alu_res = d | s;
			ALU_AND: alu_res = d & s;
			ALU_LSH: alu_res = d << sh;
			ALU_RSH: alu_res = d >> sh;
			ALU_NEG: alu_res = '0 - d;
			ALU_MOD: alu_res = (s == '0) ? d : rem;
			ALU_XOR: alu_res = d ^ s;
			ALU_MOV: alu_res = s;
			ALU_ARSH: alu_res = XLEN'($signed(d) >>> sh);
			default: alu_res = d;
		endcase
	end

	assign res = is_alu ? alu_res : imm64;

	always_comb begin
		take = 1'b0;
		is_exit = 1'b0;
		jmp_ok = 1'b1;
		case (oper)
			JMP_JA: take = 1'b1;
			JMP_JEQ: take = (d == s);
			JMP_JGT: take = (d > s);
			JMP_JGE: take = (d >= s);
			JMP_JSET: take = ((d & s) != '0);
			JMP_JNE: take = (d != s);
			JMP_JSGT: take = slt_sd;
			JMP_JSGE: take = !slt_ds;
			JMP_EXIT: is_exit = 1'b1;
			JMP_JLT: take = (d < s);
			JMP_JLE: take = (d <= s);
			JMP_JSLT: take = slt_ds;
			JMP_JSLE: take = !slt_sd;
			default: jmp_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (mul_cnt_q)
			2'd0: begin
				mul_a = d[31:0];
				mul_b = s[31:0];
			end
			2'd1: begin
				mul_a = d[63:32];
				mul_b = s[31:0];
			end
			default: begin
				mul_a = d[31:0];
				mul_b = s[63:32];
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (cmd.load) begin
			mul_cnt_q <= '0;
		end else if (cmd.mul_step) begin
			mul_cnt_q <= mul_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			if (mul_cnt_q == 2'd0) begin
				mul_acc_q <= mul_p;
			end else begin
				mul_acc_q <= mul_acc_q + {mul_p[31:0], 32'd0};
			end
		end
	end

	ebpf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(d),
		.divisor(s),
		.done(div_done),
		.quotient(quo),
		.remainder(rem)
	);

	assign status.is_mul = is_alu && (oper == ALU_MUL);
	assign status.is_div = is_alu && ((oper == ALU_DIV) || (oper == ALU_MOD)) && (s != '0);
	assign status.mul_done = cmd.mul_step && (mul_cnt_q == 2'd2);
	assign status.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			unsupported <= !(alu_ok || is_ld || (is_jmp && jmp_ok));
			exit_flag <= is_jmp && is_exit;
			if (is_jmp && is_exit) begin
				jump_delta <= '0;
			end else if (is_jmp && take) begin
				jump_delta <= 17'sd1 + 17'(off_s1);
			end else begin
				jump_delta <= 17'sd1;
			end
			return_value <= (wr && (dst_s1 == 4'd0)) ? res : r0_q;
		end
	end

endmodule

FILE: rtl/ebpf_chk.sv
module ebpf_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [16:0] jump_delta,
	input logic exit_flag,
	input logic unsupported
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output valid dropped without a transfer.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input accepted while an instruction was in progress.");

	a_exit_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exit_flag |-> jump_delta == 17'sd0 && !unsupported)
		else $error("Exit result with a non-zero delta or unsupported flag.");

	a_unsup_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> jump_delta == 17'sd1)
		else $error("Unsupported result with a delta other than one.");

endmodule

bind ebpf_alu64_branch_execute ebpf_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.jump_delta(out_ch.jump_delta),
	.exit_flag(out_ch.exit_flag),
	.unsupported(out_ch.unsupported)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ebpf_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1330;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [16:0] jump_delta;
		logic exit_flag;
		logic [63:0] return_value;
		logic unsupported;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;

	ebpf_in_if in_ch ();
	ebpf_out_if out_ch ();

	ebpf_alu64_branch_execute uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #10 clk = ~clk;

	logic [63:0] gpr [NUM_GPR];
	logic [63:0] fp_value;
	exec_result_t pending_results[$];
	int error_count = 0;
	longint unsigned cycle_count = 0;
	bit quiet_mode = 1'b0;
	bit hold_request = 1'b0;
	bit hold_seen = 1'b0;
	int hold_cycles = 0;

	function automatic logic [63:0] read_gpr(input logic [3:0] idx);
		if (idx < NUM_GPR)
			return gpr[idx];
		if (idx == FP_INDEX)
			return fp_value;
		return '0;
	endfunction

	function automatic bit signed_less(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic exec_result_t execute_instruction(input logic [7:0] op,
			input logic [3:0] di, input logic [3:0] si, input logic signed [15:0] off,
			input logic signed [31:0] imm);
		exec_result_t r;
		logic [63:0] d, s, v, imm64;
		logic [5:0] sh;
		logic [3:0] oper;
		bit take, wr;
		r.jump_delta = 17'sd1;
		r.exit_flag = 1'b0;
		r.unsupported = 1'b0;
		imm64 = {{32{imm[31]}}, imm};
		oper = op[7:4];
		d = read_gpr(di);
		s = op[3] ? read_gpr(si) : imm64;
		sh = s[5:0];
		take = 1'b0;
		wr = 1'b1;
		v = d;
		if (op[2:0] == CLS_ALU64) begin
			case (oper)
				ALU_ADD: v = d + s;
				ALU_SUB: v = d - s;
				ALU_MUL: v = d * s;
				ALU_DIV: v = (s == 0) ? 64'd0 : d / s;
				ALU_OR: v = d | s;
				ALU_AND: v = d & s;
				ALU_LSH: v = d << sh;
				ALU_RSH: v = d >> sh;
				ALU_NEG: v = -d;
				ALU_MOD: v = (s == 0) ? d : d % s;
				ALU_XOR: v = d ^ s;
				ALU_MOV: v = s;
				ALU_ARSH: v = $signed(d) >>> sh;
				default: begin
					wr = 1'b0;
					r.unsupported = 1'b1;
				end
			endcase
			if (wr && di < NUM_GPR)
				gpr[di] = v;
		end else if (op[2:0] == CLS_JMP) begin
			case (oper)
				JMP_JA: take = 1'b1;
				JMP_JEQ: take = d == s;
				JMP_JGT: take = d > s;
				JMP_JGE: take = d >= s;
				JMP_JSET: take = (d & s) != 0;
				JMP_JNE: take = d != s;
				JMP_JSGT: take = signed_less(s, d);
				JMP_JSGE: take = !signed_less(d, s);
				JMP_EXIT: r.exit_flag = 1'b1;
				JMP_JLT: take = d < s;
				JMP_JLE: take = d <= s;
				JMP_JSLT: take = signed_less(d, s);
				JMP_JSLE: take = !signed_less(s, d);
				default: r.unsupported = 1'b1;
			endcase
			if (r.exit_flag)
				r.jump_delta = '0;
			else if (take)
				r.jump_delta = 17'sd1 + off;
		end else if (op == OP_LDDW) begin
			if (di < NUM_GPR)
				gpr[di] = imm64;
		end else begin
			r.unsupported = 1'b1;
		end
		r.return_value = gpr[0];
		return r;
	endfunction

	task automatic send_instruction(input logic [7:0] op, input logic [3:0] di,
			input logic [3:0] si, input logic signed [15:0] off,
			input logic signed [31:0] imm);
		while (!quiet_mode && $urandom_range(99) < 15) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.dst_index <= di;
		in_ch.src_index <= si;
		in_ch.offset <= off;
		in_ch.immediate <= imm;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_results.push_back(execute_instruction(op, di, si, off, imm));
	endtask

	task automatic write_frame_base(input logic [63:0] value);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		fp_value = value;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_request != hold_seen) begin
			hold_seen <= hold_request;
			hold_cycles <= 300;
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ch.ready <= quiet_mode || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.jump_delta !== want.jump_delta) begin
					$error("jump_delta: expected %0d, got %0d", want.jump_delta,
						out_ch.jump_delta);
					error_count++;
				end
				if (out_ch.exit_flag !== want.exit_flag) begin
					$error("exit_flag: expected %0b, got %0b", want.exit_flag,
						out_ch.exit_flag);
					error_count++;
				end
				if (out_ch.return_value !== want.return_value) begin
					$error("return_value: expected %h, got %h", want.return_value,
						out_ch.return_value);
					error_count++;
				end
				if (out_ch.unsupported !== want.unsupported) begin
					$error("unsupported: expected %0b, got %0b", want.unsupported,
						out_ch.unsupported);
					error_count++;
				end
			end
		end
	end

	function automatic logic [63:0] random_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return {32'd0, $urandom()} & 64'h7f;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [7:0] random_opcode();
		logic [3:0] oper;
		oper = $urandom_range(15);
		case ($urandom_range(9))
			0, 1, 2, 3: return {oper, 1'($urandom()), CLS_ALU64};
			4, 5, 6: return {oper, 1'($urandom()), CLS_JMP};
			7: return OP_LDDW;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic test_directed_alu();
		logic [3:0] oper;
		send_instruction(OP_LDDW, 4'd1, 4'd0, 16'sd0, 32'sh8000_0000);
		send_instruction(OP_LDDW, 4'd2, 4'd0, 16'sd0, 32'sd7);
		send_instruction(OP_LDDW, 4'd10, 4'd0, 16'sd0, 32'sd5);
		send_instruction(OP_LDDW, 4'd15, 4'd0, 16'sd0, 32'sd5);
		for (int i = 0; i < 16; i++) begin
			oper = i;
			send_instruction({oper, 1'b1, CLS_ALU64}, 4'd0, 4'd1, 16'sd0, 32'sd0);
		end
		send_instruction({ALU_DIV, 1'b0, CLS_ALU64}, 4'd1, 4'd0, 16'sd0, 32'sd0);
		send_instruction({ALU_MOD, 1'b1, CLS_ALU64}, 4'd2, 4'd12, 16'sd0, 32'sd0);
		send_instruction({ALU_ARSH, 1'b0, CLS_ALU64}, 4'd1, 4'd0, 16'sd0, 32'sd127);
		send_instruction({ALU_MOV, 1'b1, CLS_ALU64}, 4'd3, 4'd10, 16'sd0, 32'sd0);
	endtask

	task automatic test_directed_jumps();
		logic [3:0] oper;
		for (int i = 0; i < 16; i++) begin
			oper = i;
			send_instruction({oper, 1'($urandom()), CLS_JMP}, 4'd1, 4'd2,
				(i % 2) ? 16'sh7fff : 16'sh8000, 32'sd7);
		end
	endtask

	task automatic test_random_program(input int count);
		for (int i = 0; i < count; i++)
			send_instruction(random_opcode(), 4'($urandom_range(i % 7 == 0 ? 15 : 10)),
				4'($urandom_range(i % 7 == 3 ? 15 : 10)), 16'($urandom()),
				32'(random_word()));
	endtask

	task automatic test_output_backpressure();
		hold_request = !hold_request;
		for (int i = 0; i < 20; i++)
			send_instruction({ALU_ADD, 1'b0, CLS_ALU64}, 4'($urandom_range(9)), 4'd0,
				16'sd0, 32'($urandom()));
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = '0;
		in_ch.dst_index = '0;
		in_ch.src_index = '0;
		in_ch.offset = '0;
		in_ch.immediate = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		fp_value = '0;
		for (int i = 0; i < NUM_GPR; i++)
			gpr[i] = '0;
		@(posedge clk);
		test_directed_alu();
		test_directed_jumps();
		write_frame_base('1);
		test_random_program(RANDOM_ITEMS / 4);
		write_frame_base('0);
		test_output_backpressure();
		quiet_mode = 1'b1;
		test_random_program(RANDOM_ITEMS / 4);
		quiet_mode = 1'b0;
		write_frame_base({$urandom(), $urandom()});
		test_random_program(RANDOM_ITEMS / 2);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
